FILE: rtl/core/hmr_pkg.sv
package hmr_pkg;

	// Input item kinds
	localparam logic [1:0] KIND_INIT = 2'd0;
	localparam logic [1:0] KIND_CONT = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	// Result item kinds
	localparam logic [1:0] OUT_START = 2'd0;
	localparam logic [1:0] OUT_DATA  = 2'd1;
	localparam logic [1:0] OUT_ABORT = 2'd2;
	localparam logic [1:0] OUT_REPLY = 2'd3;

	// Error reply codes
	localparam logic ERR_BUSY = 1'b0;
	localparam logic ERR_SEQ  = 1'b1;

	// Result queue: room for two bursts of two results
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] channel_id;
		logic [7:0]  cmd_or_seq;
		logic [15:0] byte_count;
		logic [7:0]  payload_byte;
	} pkt_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [31:0] out_channel;
		logic [7:0]  out_command;
		logic [15:0] out_length;
		logic [7:0]  out_byte;
		logic        out_last;
		logic        error_code;
	} msg_item_t;

endpackage

FILE: rtl/core/hmr_pkt_if.sv
interface hmr_pkt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] channel_id;
	logic [7:0]  cmd_or_seq;
	logic [15:0] byte_count;
	logic [7:0]  payload_byte;

	modport source (output valid, kind, channel_id, cmd_or_seq, byte_count, payload_byte,
		input ready);
	modport sink (input valid, kind, channel_id, cmd_or_seq, byte_count, payload_byte,
		output ready);
endinterface

FILE: rtl/core/hmr_msg_if.sv
interface hmr_msg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic [31:0] out_channel;
	logic [7:0]  out_command;
	logic [15:0] out_length;
	logic [7:0]  out_byte;
	logic        out_last;
	logic        error_code;

	modport source (output valid, out_kind, out_channel, out_command, out_length, out_byte,
		out_last, error_code, input ready);
	modport sink (input valid, out_kind, out_channel, out_command, out_length, out_byte,
		out_last, error_code, output ready);
endinterface

FILE: rtl/core/hid_message_reassembler_top.sv
// Channel   Dir   Handshake      Carries
// pkt       in    valid/ready    kind, channel_id, cmd_or_seq, byte_count, payload_byte
// msg       out   valid/ready    out_kind, out_channel, out_command, out_length,
//                                out_byte, out_last, error_code
//
// A request is registered in the input stage and decoded against the message state
// once two queue slots are free; its zero, one or two results then wait in a four-entry result queue.
// One request is taken every cycle while the queue has room for two results, so the
// queue depth alone sets when a stalled output side holds off the input side.
// arst_n clears the message state, the input stage and the queue at once.
module hid_message_reassembler_top (
	input  logic       clk,
	input  logic       arst_n,
	hmr_pkt_if.sink    pkt,
	hmr_msg_if.source  msg
);

	// Input stage
	logic                valid_s1;
	hmr_pkg::pkt_item_t  item_s1;

	// Message state
	logic        busy_q;
	logic [31:0] open_channel_q;
	logic [7:0]  open_command_q;
	logic [15:0] expected_length_q;
	logic [15:0] received_count_q;
	logic [7:0]  expected_seq_q;

	// Next message state, applied only when the staged request is decoded
	logic        busy_d;
	logic [31:0] open_channel_d;
	logic [7:0]  open_command_d;
	logic [15:0] expected_length_d;
	logic [15:0] received_count_d;
	logic [7:0]  expected_seq_d;

	// Result queue
	hmr_pkg::msg_item_t        q_mem [hmr_pkg::Q_DEPTH];
	logic [hmr_pkg::Q_AW-1:0]  wr_ptr_q;
	logic [hmr_pkg::Q_AW-1:0]  rd_ptr_q;
	logic [hmr_pkg::Q_CW-1:0]  q_cnt_q;

	hmr_pkg::msg_item_t  res0;
	hmr_pkg::msg_item_t  res1;
	logic [1:0]          n_res;
	logic [15:0]         count_inc;
	logic                fire;
	logic                pop;
	hmr_pkg::msg_item_t  head;

	// Decode the staged request only when two queue slots are free
	assign fire      = valid_s1 && (q_cnt_q <= hmr_pkg::Q_CW'(hmr_pkg::Q_DEPTH - 2));
	assign pkt.ready = !valid_s1 || fire;
	assign pop       = msg.valid && msg.ready;
	assign count_inc = received_count_q + 16'd1;

	always_comb begin
		busy_d            = busy_q;
		open_channel_d    = open_channel_q;
		open_command_d    = open_command_q;
		expected_length_d = expected_length_q;
		received_count_d  = received_count_q;
		expected_seq_d    = expected_seq_q;
		res0              = '0;
		res1              = '0;
		n_res             = 2'd0;
		case (item_s1.kind)
			hmr_pkg::KIND_INIT: begin
				n_res = 2'd1;
				if (!busy_q) begin
					// Open a message; a zero-length one completes at once
					open_channel_d    = item_s1.channel_id;
					open_command_d    = item_s1.cmd_or_seq;
					expected_length_d = item_s1.byte_count;
					received_count_d  = 16'd0;
					expected_seq_d    = 8'd0;
					busy_d            = (item_s1.byte_count != 16'd0);
					res0.out_kind     = hmr_pkg::OUT_START;
					res0.out_channel  = item_s1.channel_id;
					res0.out_command  = item_s1.cmd_or_seq;
					res0.out_length   = item_s1.byte_count;
					res0.out_last     = (item_s1.byte_count == 16'd0);
				end else begin
					// Init while open: abort and drop the header
					busy_d           = 1'b0;
					res0.out_kind    = hmr_pkg::OUT_ABORT;
					res0.out_channel = open_channel_q;
				end
			end
			hmr_pkg::KIND_CONT: begin
				if (busy_q) begin
					if (item_s1.channel_id != open_channel_q) begin
						// Foreign channel: abort, reply busy to the sender
						busy_d           = 1'b0;
						n_res            = 2'd2;
						res0.out_kind    = hmr_pkg::OUT_ABORT;
						res0.out_channel = open_channel_q;
						res1.out_kind    = hmr_pkg::OUT_REPLY;
						res1.out_channel = item_s1.channel_id;
						res1.error_code  = hmr_pkg::ERR_BUSY;
					end else if (item_s1.cmd_or_seq != expected_seq_q) begin
						busy_d           = 1'b0;
						n_res            = 2'd2;
						res0.out_kind    = hmr_pkg::OUT_ABORT;
						res0.out_channel = open_channel_q;
						res1.out_kind    = hmr_pkg::OUT_REPLY;
						res1.out_channel = open_channel_q;
						res1.error_code  = hmr_pkg::ERR_SEQ;
					end else begin
						expected_seq_d = expected_seq_q + 8'd1;
					end
				end
			end
			hmr_pkg::KIND_DATA: begin
				if (busy_q) begin
					n_res            = 2'd1;
					received_count_d = count_inc;
					res0.out_kind    = hmr_pkg::OUT_DATA;
					res0.out_channel = open_channel_q;
					res0.out_byte    = item_s1.payload_byte;
					res0.out_last    = (count_inc == expected_length_q);
					if (count_inc == expected_length_q) begin
						busy_d = 1'b0;
					end
				end
			end
			default: begin
				// Undefined kind: no change, no result
			end
		endcase
	end

	// Input stage: advance whenever the slot is free or being decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			item_s1.kind         <= pkt.kind;
			item_s1.channel_id   <= pkt.channel_id;
			item_s1.cmd_or_seq   <= pkt.cmd_or_seq;
			item_s1.byte_count   <= pkt.byte_count;
			item_s1.payload_byte <= pkt.payload_byte;
		end
	end

	// Message state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q            <= 1'b0;
			open_channel_q    <= '0;
			open_command_q    <= '0;
			expected_length_q <= '0;
			received_count_q  <= '0;
			expected_seq_q    <= '0;
		end else if (fire) begin
			busy_q            <= busy_d;
			open_channel_q    <= open_channel_d;
			open_command_q    <= open_command_d;
			expected_length_q <= expected_length_d;
			received_count_q  <= received_count_d;
			expected_seq_q    <= expected_seq_d;
		end
	end

	// Queue storage: push up to two results in order
	always_ff @(posedge clk) begin
		if (fire && (n_res != 2'd0)) begin
			q_mem[wr_ptr_q] <= res0;
		end
		if (fire && (n_res == 2'd2)) begin
			q_mem[wr_ptr_q + hmr_pkg::Q_AW'(1)] <= res1;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			q_cnt_q  <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q + hmr_pkg::Q_AW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hmr_pkg::Q_AW'(1);
			end
			q_cnt_q <= q_cnt_q + (fire ? hmr_pkg::Q_CW'(n_res) : '0)
				- (pop ? hmr_pkg::Q_CW'(1) : '0);
		end
	end

	// Present the queue head
	assign head            = q_mem[rd_ptr_q];
	assign msg.valid       = (q_cnt_q != '0);
	assign msg.out_kind    = head.out_kind;
	assign msg.out_channel = head.out_channel;
	assign msg.out_command = head.out_command;
	assign msg.out_length  = head.out_length;
	assign msg.out_byte    = head.out_byte;
	assign msg.out_last    = head.out_last;
	assign msg.error_code  = head.error_code;

endmodule
